[design/assert_macros.svh]
// Assertion macros for the linear-probe address counter top level.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the synchronous reset is low.
`define LPAC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LPAC_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lpac_pkg.sv]
// Shared types and constants for the linear-probe address counter.
// No dependencies; imported by the hash unit and the top level.
package lpac_pkg;

  localparam int ADDR_W      = 64;
  localparam int HASH_W      = 32;
  localparam int SLOT_W      = 9;
  localparam int COUNT_W     = 32;
  localparam int STEP_W      = 9;
  localparam int OUTC_W      = 2;
  localparam int OUT_TDATA_W = 56;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [OUTC_W-1:0] {
    OUTC_HIT  = 2'd0,
    OUTC_NEW  = 2'd1,
    OUTC_FULL = 2'd2
  } outcome_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_HASH  = 4'b0100,
    ST_PROBE = 4'b1000
  } state_t;

  // Status of the home-slot unit as seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } hash_stat_t;

endpackage

[design/lpac_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instantiated for the key and count stores.
module lpac_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/lpac_hash.sv]
// Home-slot unit: shifts the address and reduces it modulo the table size.
// Depends on lpac_pkg. A power-of-two table is a mask; otherwise a reciprocal multiply.
module lpac_hash
  import lpac_pkg::*;
#(
  parameter int TABLE_ENTRIES = 512,
  parameter int HASH_SHIFT    = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ADDR_W-1:0]                addr,
  output logic [$clog2(TABLE_ENTRIES)-1:0] home,
  output hash_stat_t                       stat
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  logic [HASH_W-1:0] hv;
  assign hv = addr[HASH_SHIFT +: HASH_W];

  if (IS_POW2) begin : g_mask
    assign home = hv[IW-1:0];
    assign stat.busy = 1'b0;
    assign stat.done = start;
  end else begin : g_rem
    // The quotient estimate from the scaled reciprocal is exact or one short,
    // so the remainder needs only its low bits and one compare and subtract.
    localparam int MUL_SH = HASH_W - 1 + IW;
    localparam logic [HASH_W-1:0] MUL = HASH_W'((64'd1 << MUL_SH) / TABLE_ENTRIES);
    localparam logic [IW:0] NW = (IW+1)'(TABLE_ENTRIES);

    logic [HASH_W-1:0]   v_r;
    logic [2*HASH_W-1:0] prod_r;
    logic [IW:0]         quo_lo;
    logic [IW:0]         qn;
    logic [IW:0]         rem_est;
    logic [IW:0]         rem_r;
    logic [IW:0]         rem_nxt;
    logic                phase_r;
    logic                busy_r;
    logic                done_r;

    assign quo_lo  = prod_r[MUL_SH +: (IW+1)];
    assign qn      = quo_lo * NW;
    assign rem_est = v_r[IW:0] - qn;
    assign rem_nxt = (rem_est >= NW) ? (rem_est - NW) : rem_est;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r  <= 1'b0;
        phase_r <= 1'b0;
        done_r  <= 1'b0;
      end else begin
        done_r <= busy_r && phase_r;
        if (start) begin
          busy_r  <= 1'b1;
          phase_r <= 1'b0;
        end else if (busy_r) begin
          phase_r <= 1'b1;
          if (phase_r) begin
            busy_r <= 1'b0;
          end
        end
      end
    end

    // The busy phase first registers the product, then the corrected remainder.
    always_ff @(posedge clk) begin
      if (start) begin
        v_r <= hv;
      end
      if (busy_r && !phase_r) begin
        prod_r <= (2*HASH_W)'(v_r) * (2*HASH_W)'(MUL);
      end
      if (busy_r && phase_r) begin
        rem_r <= rem_nxt;
      end
    end

    assign home      = rem_r[IW-1:0];
    assign stat.busy = busy_r;
    assign stat.done = done_r;
  end

endmodule

[design/linear_probe_address_counter.sv]
// Top level of the linear-probe address counter: controller, stores and output register.
// Depends on lpac_pkg, lpac_ram, lpac_hash and assert_macros.svh.
//
//   Channel | Direction | Word                                          | Handshake
//   in_     | in        | address                                       | tvalid/tready
//   out_    | out       | slot_index, new_count, outcome, probe_steps   | tvalid/tready
//
// An item is accepted in idle; the probe state then reads slot after slot until a hit,
// an empty slot or a full table, bound by the registered read of the key and count stores.
// A table size that is not a power of two adds a hash state for the reciprocal-multiply remainder.
// After reset a clearing pass writes every slot before the first accept.
// A result waits in the output register; a finished probe holds until that register frees.
module linear_probe_address_counter
  import lpac_pkg::*;
#(
  parameter int TABLE_ENTRIES = 512,
  parameter int HASH_SHIFT    = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [ADDR_W-1:0]      in_tdata,   // [63:0] address
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [8:0] slot_index, [40:9] new_count,
                                             // [42:41] outcome, [51:43] probe_steps, rest 0
);

  `include "assert_macros.svh"

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               zero_r, zero_nxt;
  logic [IW-1:0]      slot_r, slot_nxt;
  logic [IW-1:0]      step_r, step_nxt;
  logic [IW-1:0]      clr_r, clr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic               in_acc;
  logic               hash_start;
  logic [IW-1:0]      home;
  hash_stat_t         hstat;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [IW-1:0]      ram_raddr;
  logic [ADDR_W-1:0]  wr_key;
  logic [COUNT_W-1:0] wr_cnt;
  logic [ADDR_W-1:0]  rd_key;
  logic [COUNT_W-1:0] rd_cnt;

  logic               hit;
  logic               empty;
  logic               probe_done;
  logic               out_free;
  logic [IW-1:0]      slot_inc;
  logic [COUNT_W-1:0] cnt_inc;
  logic [31:0]        slot_ext;
  logic [31:0]        step_ext;
  outcome_t           outc;
  logic [SLOT_W-1:0]  res_slot;
  logic [COUNT_W-1:0] res_cnt;
  logic [STEP_W-1:0]  res_step;

  logic               probe_wr;
  logic               probe_go;
  logic               clearing;

  lpac_hash #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .HASH_SHIFT    (HASH_SHIFT)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .addr  (in_tdata),
    .home  (home),
    .stat  (hstat)
  );

  lpac_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_key),
    .raddr (ram_raddr),
    .rdata (rd_key)
  );

  lpac_ram #(.WIDTH(COUNT_W), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_cnt),
    .raddr (ram_raddr),
    .rdata (rd_cnt)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign hash_start = in_acc && (in_tdata != '0);

  assign hit        = (rd_key == addr_r);
  assign empty      = (rd_key == '0);
  assign probe_done = zero_r || hit || empty || (step_r == LAST);
  assign out_free   = !out_valid_r || out_tready;
  assign slot_inc   = (slot_r == LAST) ? '0 : slot_r + 1'b1;
  assign cnt_inc    = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
  assign slot_ext   = 32'(slot_r);
  assign step_ext   = 32'(step_r);

  // Result fields; a zero address or a full table reports zeros.
  always_comb begin
    if (zero_r || (!hit && !empty)) begin
      outc     = OUTC_FULL;
      res_slot = '0;
      res_cnt  = '0;
      res_step = '0;
    end else if (hit) begin
      outc     = OUTC_HIT;
      res_slot = slot_ext[SLOT_W-1:0];
      res_cnt  = cnt_inc;
      res_step = step_ext[STEP_W-1:0];
    end else begin
      outc     = OUTC_NEW;
      res_slot = slot_ext[SLOT_W-1:0];
      res_cnt  = COUNT_W'(1);
      res_step = step_ext[STEP_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    zero_nxt      = zero_r;
    slot_nxt      = slot_r;
    step_nxt      = step_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_raddr     = slot_r;
    wr_key        = addr_r;
    wr_cnt        = res_cnt;

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        wr_key    = '0;
        wr_cnt    = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          addr_nxt = in_tdata;
          zero_nxt = (in_tdata == '0);
          step_nxt = '0;
          if (in_tdata == '0) begin
            state_nxt = ST_PROBE;
          end else if (hstat.done) begin
            ram_raddr = home;
            slot_nxt  = home;
            state_nxt = ST_PROBE;
          end else begin
            state_nxt = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hstat.done) begin
          ram_raddr = home;
          slot_nxt  = home;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (probe_done && out_free) begin
          ram_we        = !zero_r && (hit || empty);
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({res_step, outc, res_cnt, res_slot});
          state_nxt     = ST_IDLE;
        end else if (probe_done) begin
          // Output register still full: read the same slot again to keep its data.
          ram_raddr = slot_r;
        end else begin
          ram_raddr = slot_inc;
          slot_nxt  = slot_inc;
          step_nxt  = step_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      zero_r      <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      zero_r      <= zero_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign probe_wr = (state_r == ST_PROBE) && ram_we;
  assign probe_go = (state_r == ST_PROBE) && !probe_done;
  assign clearing = (state_r == ST_CLEAR);

  `LPAC_ASSERT(a_write_loads_out, clk, rst_n, probe_wr |=> out_valid_r, "update without a result")
  `LPAC_ASSERT(a_step_adv, clk, rst_n, probe_go |=> (step_r == $past(step_r) + 1'b1), "step stuck")
  `LPAC_ASSERT(a_no_zero_key, clk, rst_n, probe_wr |-> (wr_key != '0), "zero key written")
  `LPAC_ASSERT(a_clear_holds, clk, rst_n, (clearing && clr_r != LAST) |=> clearing, "early end")
  `LPAC_ASSERT(a_hash_busy, clk, rst_n, hstat.busy |-> (state_r == ST_HASH), "stray hash busy")

endmodule
